// File: hw/rtl/mnva_pkg.sv
// ----------------------------------------------------------------------------
// mnva_pkg
// Shared types, constants and the pitch table for the MIDI note voice
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package mnva_pkg;

  // Pool size default and per-message write limit
  localparam int VOICES_DEF = 9;
  localparam int MAX_WRITES = 9;

  // Message kinds
  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_CTRL     = 2'd2,
    KIND_ALL_OFF  = 2'd3
  } kind_t;

  // Which write the datapath forms
  typedef enum logic [1:0] {
    EMIT_ATTN    = 2'd0,
    EMIT_FNUM_LO = 2'd1,
    EMIT_KEY_ON  = 2'd2,
    EMIT_KEY_OFF = 2'd3
  } emit_op_t;

  // Synthesizer register map
  localparam logic [7:0] ADDR_ATTN    = 8'h40;
  localparam logic [7:0] ADDR_FNUM_LO = 8'hA0;
  localparam logic [7:0] ADDR_KEY     = 8'hB0;
  localparam logic [7:0] KEY_ON_BIT   = 8'h20;
  localparam logic [7:0] ATTN_BANK    = 8'd9;

  // Volume handling
  localparam logic [6:0] LEVEL_RESET = 7'd100;
  localparam logic [6:0] VOL_CTRL    = 7'd7;
  localparam logic [5:0] ATTN_MAX    = 6'd63;
  localparam int         DIV_BY      = 127;
  // products at or above this give a level over 63 (attenuation 0)
  localparam logic [13:0] ATTN_CLIP  = 14'(64 * DIV_BY);
  // floor(p/127) = (p * RECIP) >> RECIP_SH, exact for p < 16644
  localparam int          RECIP_SH   = 20;
  localparam logic [13:0] RECIP      = 14'(((1 << RECIP_SH) + DIV_BY - 1) / DIV_BY);
  localparam logic [31:0] TICK_MAX   = 32'hFFFF_FFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic     take;
    logic     level_wr;
    logic     scan_clr;
    logic     scan_step;
    logic     scan_track;
    logic     voice_clr;
    logic     alloc;
    logic     emit;
    emit_op_t op;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_t kind;
    logic  release_msg;
    logic  vol_ctrl;
    logic  scan_last;
    logic  cur_active;
    logic  rel_match;
    logic  off_room;
    logic  out_free;
  } ctl_sts_t;

  // Pitch table: block in [12:10], F-number in [9:0]
  typedef logic [12:0] pitch_t;
  typedef logic [127:0][12:0] pitch_tab_t;

  // 2^(r/12) scaled by 10^12
  localparam logic [63:0] SEMI_RATIO [12] = '{
    64'd1000000000000, 64'd1059463094359, 64'd1122462048309, 64'd1189207115003,
    64'd1259921049895, 64'd1334839854170, 64'd1414213562373, 64'd1498307076877,
    64'd1587401051968, 64'd1681792830507, 64'd1781797436281, 64'd1887748625363
  };
  localparam logic [63:0] PITCH_DEN = 64'd49716000000000000;

  // Equal-tempered table, evaluated at elaboration only
  function automatic pitch_tab_t build_pitch_tab();
    pitch_tab_t  tab;
    logic [63:0] rem;
    logic [63:0] quot;
    logic [63:0] f;
    int          oct;
    int          semi;
    int          shifts;
    logic [2:0]  blk;
    logic [9:0]  fn;
    logic        done;
    tab  = '0;
    oct  = 0;
    semi = 3;
    for (int n = 0; n < 128; n++) begin
      rem    = 64'd440 * SEMI_RATIO[semi];
      quot   = '0;
      shifts = oct + 46;
      // block-0 F-number with 32 fraction bits, restoring long division
      for (int i = 0; i < 64; i++) begin
        if (i < shifts) begin
          rem  = rem << 1;
          quot = quot << 1;
          if (rem >= PITCH_DEN) begin
            rem     = rem - PITCH_DEN;
            quot[0] = 1'b1;
          end
        end
      end
      blk  = 3'd7;
      fn   = 10'd1023;
      done = 1'b0;
      for (int b = 0; b < 8; b++) begin
        f = quot >> b;
        if (!done && (f <= (64'd1023 << 32))) begin
          blk  = 3'(b);
          fn   = 10'((f + 64'h8000_0000) >> 32);
          done = 1'b1;
        end
      end
      tab[n] = {blk, fn};
      // advance octave and semitone
      if (semi == 11) begin
        semi = 0;
        oct  = oct + 1;
      end else begin
        semi = semi + 1;
      end
    end
    return tab;
  endfunction

  localparam pitch_tab_t PITCH_TAB = build_pitch_tab();

endpackage

`default_nettype wire

// File: hw/rtl/mnva_dp.sv
// ----------------------------------------------------------------------------
// mnva_dp
// Datapath: message latch, voice pool, channel levels, voice scan trackers,
// attenuation arithmetic and the registered write output.
// ----------------------------------------------------------------------------
`default_nettype none

module mnva_dp #(
  parameter int VOICES = mnva_pkg::VOICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         kind,
  input  logic [3:0]         channel,
  input  logic [6:0]         data_first,
  input  logic [6:0]         data_second,
  input  logic [31:0]        now_tick,
  output logic [7:0]         reg_addr,
  output logic [7:0]         reg_data,
  output logic               last_write,
  output logic               wr_valid,
  input  logic               wr_stall,
  input  mnva_pkg::ctl_cmd_t cmd,
  output mnva_pkg::ctl_sts_t sts
);
  import mnva_pkg::*;

  localparam int IW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int WCW = $clog2(MAX_WRITES + 1);

  // latched message
  kind_t       kind_q;
  logic [3:0]  ch_q;
  logic [6:0]  note_q;
  logic [6:0]  vel_q;
  logic [31:0] tick_q;

  // voice pool and channel levels
  logic [VOICES-1:0] voice_active;
  logic [3:0]        voice_channel [VOICES];
  logic [6:0]        voice_note    [VOICES];
  logic [31:0]       voice_start   [VOICES];
  logic [6:0]        channel_level [16];

  // scan state
  logic [IW-1:0]  idx;
  logic           found_free;
  logic [IW-1:0]  free_idx;
  logic [31:0]    oldest;
  logic [IW-1:0]  old_idx;
  logic [WCW-1:0] wcnt;

  // arithmetic
  logic [13:0] prod;
  logic [26:0] recip_prod;
  logic [5:0]  tl;

  logic [IW-1:0]     sel;
  logic [VOICES-1:0] above;
  logic [6:0]        note_rd;
  pitch_t            pe;
  logic [7:0]        key_bits;
  logic [7:0]        sel8;
  logic [7:0]        idx8;
  logic [7:0]        attn_slot;
  logic              out_free;
  logic [7:0]        addr_n;
  logic [7:0]        data_n;
  logic              last_n;

  // message latch
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_q <= kind_t'(kind);
      ch_q   <= channel;
      note_q <= data_first;
      vel_q  <= data_second;
      tick_q <= now_tick;
    end
  end

  // channel volume
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 16; c++) channel_level[c] <= LEVEL_RESET;
    end else if (cmd.level_wr) begin
      channel_level[ch_q] <= vel_q;
    end
  end

  // attenuation: product, then divide by 127 through the reciprocal
  assign recip_prod = 27'(prod[12:0]) * 27'(RECIP);
  always_ff @(posedge clk) begin
    prod <= 14'(vel_q) * 14'(channel_level[ch_q]);
    tl   <= (prod >= ATTN_CLIP) ? 6'd0 : ATTN_MAX - recip_prod[RECIP_SH+5:RECIP_SH];
  end

  // voice pool updates
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active <= '0;
      for (int v = 0; v < VOICES; v++) begin
        voice_channel[v] <= '0;
        voice_note[v]    <= '0;
        voice_start[v]   <= '0;
      end
    end else begin
      if (cmd.voice_clr) voice_active[idx] <= 1'b0;
      if (cmd.alloc) begin
        voice_active[sel]  <= 1'b1;
        voice_channel[sel] <= ch_q;
        voice_note[sel]    <= note_q;
        voice_start[sel]   <= tick_q;
      end
    end
  end

  // voice scan: first free voice and oldest start tick
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clr) begin
      idx        <= '0;
      found_free <= 1'b0;
      free_idx   <= '0;
      oldest     <= TICK_MAX;
      old_idx    <= '0;
      wcnt       <= '0;
    end else begin
      if (cmd.scan_track) begin
        if (!found_free && !voice_active[idx]) begin
          found_free <= 1'b1;
          free_idx   <= idx;
        end
        if (voice_start[idx] < oldest) begin
          oldest  <= voice_start[idx];
          old_idx <= idx;
        end
      end
      if (cmd.voice_clr) wcnt <= wcnt + 1'b1;
      if (cmd.scan_step) idx <= idx + 1'b1;
    end
  end

  assign sel = found_free ? free_idx : old_idx;

  // active voices past the scan point
  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      above[v] = voice_active[v] && (IW'(v) > idx);
    end
  end

  // pitch lookup and write formation
  assign note_rd   = (kind_q == KIND_ALL_OFF) ? voice_note[idx] : note_q;
  assign pe        = PITCH_TAB[note_rd];
  assign key_bits  = {3'b000, pe[12:10], pe[9:8]};
  assign sel8      = 8'(sel);
  assign idx8      = 8'(idx);
  assign attn_slot = (sel8 >= ATTN_BANK) ? sel8 - ATTN_BANK : sel8;

  always_comb begin
    case (cmd.op)
      EMIT_ATTN: begin
        addr_n = ADDR_ATTN + attn_slot;
        data_n = {2'b00, tl};
        last_n = 1'b0;
      end
      EMIT_FNUM_LO: begin
        addr_n = ADDR_FNUM_LO + sel8;
        data_n = pe[7:0];
        last_n = 1'b0;
      end
      EMIT_KEY_ON: begin
        addr_n = ADDR_KEY + sel8;
        data_n = KEY_ON_BIT | key_bits;
        last_n = 1'b1;
      end
      default: begin
        addr_n = ADDR_KEY + idx8;
        data_n = key_bits;
        last_n = (kind_q != KIND_ALL_OFF) || (wcnt == WCW'(MAX_WRITES - 1)) || !(|above);
      end
    endcase
  end

  // output register
  assign out_free = !wr_valid || !wr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (cmd.emit) begin
      wr_valid <= 1'b1;
    end else if (!wr_stall) begin
      wr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      reg_addr   <= addr_n;
      reg_data   <= data_n;
      last_write <= last_n;
    end
  end

  // status
  assign sts.kind        = kind_q;
  assign sts.release_msg = (kind_q == KIND_NOTE_OFF) || (vel_q == 7'd0);
  assign sts.vol_ctrl    = (note_q == VOL_CTRL);
  assign sts.scan_last   = (idx == IW'(VOICES - 1));
  assign sts.cur_active  = voice_active[idx];
  assign sts.rel_match   = voice_active[idx] && (voice_channel[idx] == ch_q)
                           && (voice_note[idx] == note_q);
  assign sts.off_room    = (wcnt < WCW'(MAX_WRITES));
  assign sts.out_free    = out_free;

`ifndef ASSERT_OFF
  // a write is never loaded over one that is still stalled
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free) else $error("write loaded over a stalled beat");

  // all-off never issues more than the write limit
  a_wcnt_limit: assert property (@(posedge clk) disable iff (rst)
    wcnt <= WCW'(MAX_WRITES)) else $error("write count past limit");

  // an allocated voice is active afterwards
  a_alloc_active: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |=> voice_active[$past(sel)]) else $error("allocated voice not active");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/mnva_ctrl.sv
// ----------------------------------------------------------------------------
// mnva_ctrl
// Controller: sequences message dispatch, voice scans and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

module mnva_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  output logic               msg_stall,
  input  mnva_pkg::ctl_sts_t sts,
  output mnva_pkg::ctl_cmd_t cmd
);
  import mnva_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DISPATCH = 8'b0000_0010,
    ST_REL_SCAN = 8'b0000_0100,
    ST_ON_SCAN  = 8'b0000_1000,
    ST_ON_ATTN  = 8'b0001_0000,
    ST_ON_FNUM  = 8'b0010_0000,
    ST_ON_KEY   = 8'b0100_0000,
    ST_OFF_SCAN = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign msg_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = EMIT_KEY_OFF;
    unique case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.scan_clr = 1'b1;
        unique case (sts.kind)
          KIND_CTRL: begin
            cmd.level_wr = sts.vol_ctrl;
            state_next   = ST_IDLE;
          end
          KIND_ALL_OFF: state_next = ST_OFF_SCAN;
          default: state_next = sts.release_msg ? ST_REL_SCAN : ST_ON_SCAN;
        endcase
      end
      ST_REL_SCAN: begin
        if (sts.rel_match) begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.voice_clr = 1'b1;
            state_next    = ST_IDLE;
          end
        end else if (sts.scan_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_ON_SCAN: begin
        cmd.scan_track = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_ON_ATTN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_ON_ATTN: begin
        cmd.op = EMIT_ATTN;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.alloc  = 1'b1;
          state_next = ST_ON_FNUM;
        end
      end
      ST_ON_FNUM: begin
        cmd.op = EMIT_FNUM_LO;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_ON_KEY;
        end
      end
      ST_ON_KEY: begin
        cmd.op = EMIT_KEY_ON;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_OFF_SCAN: begin
        if (sts.cur_active && sts.off_room) begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.voice_clr = 1'b1;
            if (sts.scan_last) begin
              state_next = ST_IDLE;
            end else begin
              cmd.scan_step = 1'b1;
            end
          end
        end else if (sts.scan_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/midi_note_voice_allocator.sv
// Sequence: a message is taken, then dispatched the next cycle; the voice scan
//   then walks one voice per cycle, held in note-off and all-off while a write
//   waits on a stalled output. Each message (note-on, note-off, all-off, control
//   change) holds msg_stall until it is done; writes leave one beat per cycle
//   unless wr_stall holds the output.
// Reset: voice pool emptied, channel volumes set to 100, output empty.
// ----------------------------------------------------------------------------
// midi_note_voice_allocator
// Maps decoded MIDI channel messages onto a pool of FM voices and emits
// synthesizer register writes.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_voice_allocator #(
  parameter int VOICES = mnva_pkg::VOICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [1:0]  kind,
  input  logic [3:0]  channel,
  input  logic [6:0]  data_first,
  input  logic [6:0]  data_second,
  input  logic [31:0] now_tick,
  output logic        wr_valid,
  input  logic        wr_stall,
  output logic [7:0]  reg_addr,
  output logic [7:0]  reg_data,
  output logic        last_write
);
  import mnva_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencing
  mnva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // voice pool and write formation
  mnva_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .channel     (channel),
    .data_first  (data_first),
    .data_second (data_second),
    .now_tick    (now_tick),
    .reg_addr    (reg_addr),
    .reg_data    (reg_data),
    .last_write  (last_write),
    .wr_valid    (wr_valid),
    .wr_stall    (wr_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire
